/* hdl/stir_pkg.sv */
package stir_pkg;

  localparam int QUERY_W = 11;
  localparam int DATA_W = 30;
  localparam int RED_W = 32;

  localparam logic [DATA_W-1:0] MOD_P = 30'd1000000007;
  localparam logic [RED_W-1:0] MOD_P_X1 = 32'd1000000007;
  localparam logic [RED_W-1:0] MOD_P_X2 = 32'd2000000014;

  // Quotient estimate: q = ((v >> EST_SHIFT) * RECIP) >> RECIP_W,
  // RECIP = floor(2^(EST_SHIFT + RECIP_W) / MOD_P). Never overestimates.
  localparam int EST_SHIFT = 29;
  localparam int RECIP_W = 16;
  localparam logic [RECIP_W-1:0] RECIP = 16'd35184;

  // One column update handed from the sequencer to the multiply-add unit
  typedef struct packed {
    logic valid;
    logic hi_zero;   // column j not yet reached in this query: reads as zero
    logic lo_seed;   // column j-1 is column 0: use seed_one instead of memory
    logic seed_one;  // column 0 value of the previous row (1 only for row 0)
  } stir_op_t;

endpackage

/* hdl/stir_row_mem.sv */
module stir_row_mem import stir_pkg::*; #(
  parameter int DEPTH = 1025,
  parameter int AW = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     ra_addr,
  input  logic [AW-1:0]     rb_addr,
  output logic [DATA_W-1:0] ra_data,
  output logic [DATA_W-1:0] rb_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

/* hdl/stir_mod_mac.sv */
module stir_mod_mac import stir_pkg::*; #(
  parameter int AW = 11,
  parameter int MW = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  stir_op_t          op,
  input  logic [AW-1:0]     op_addr,
  input  logic [MW-1:0]     mult,
  input  logic [DATA_W-1:0] rd_hi,
  input  logic [DATA_W-1:0] rd_lo,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [DATA_W-1:0] wr_data,
  output logic              busy
);

  localparam int PW = MW + DATA_W;
  localparam int VW = PW + 1;
  localparam int TW = VW - EST_SHIFT;
  localparam int QW = TW;
  localparam int EW = TW + RECIP_W;
  localparam int XW = QW + DATA_W;

  // stage 0: line up with registered memory read data
  stir_op_t          op0;
  logic [AW-1:0]     addr0;
  logic [MW-1:0]     mult0;
  // stage 1: a + mult * b
  logic              val1;
  logic [AW-1:0]     addr1;
  logic [VW-1:0]     v1;
  // stage 2: quotient estimate
  logic              val2;
  logic [AW-1:0]     addr2;
  logic [VW-1:0]     v2;
  logic [QW-1:0]     q2;
  // stage 3: partial remainder, below 2*MOD_P
  logic              val3;
  logic [AW-1:0]     addr3;
  logic [RED_W-1:0]  r3;

  logic [DATA_W-1:0] opnd_a;
  logic [DATA_W-1:0] opnd_b;
  logic [PW-1:0]     prod;
  logic [VW-1:0]     v_comb;
  logic [EW-1:0]     est;
  logic [XW-1:0]     qp;
  logic [VW-1:0]     diff;
  logic [RED_W-1:0]  r_fold;

  assign opnd_b = op0.hi_zero ? '0 : rd_hi;
  assign opnd_a = op0.lo_seed ? DATA_W'(op0.seed_one) : rd_lo;
  assign prod = PW'(mult0) * PW'(opnd_b);
  assign v_comb = VW'(prod) + VW'(opnd_a);

  assign est = EW'(v1[VW-1:EST_SHIFT]) * EW'(RECIP);

  assign qp = XW'(q2) * XW'(MOD_P);
  assign diff = v2 - qp[VW-1:0];

  always_comb begin
    priority if (r3 >= MOD_P_X2) begin
      r_fold = r3 - MOD_P_X2;
    end else if (r3 >= MOD_P_X1) begin
      r_fold = r3 - MOD_P_X1;
    end else begin
      r_fold = r3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op0  <= '0;
      val1 <= 1'b0;
      val2 <= 1'b0;
      val3 <= 1'b0;
    end else begin
      op0  <= op;
      val1 <= op0.valid;
      val2 <= val1;
      val3 <= val2;
    end
    addr0 <= op_addr;
    mult0 <= mult;
    addr1 <= addr0;
    v1    <= v_comb;
    addr2 <= addr1;
    v2    <= v1;
    q2    <= est[EW-1:RECIP_W];
    addr3 <= addr2;
    r3    <= diff[RED_W-1:0];
  end

  assign wr_en = val3;
  assign wr_addr = addr3;
  assign wr_data = r_fold[DATA_W-1:0];
  assign busy = op0.valid | val1 | val2 | val3;

endmodule

/* hdl/stirling_first_kind_mod_unit.sv */
// Unsigned Stirling numbers of the first kind, c(n,k) mod 1000000007.
//
// Query channel: stick_count (n) and visible_count (k) move in one transaction
// when query_valid is high and query_stall is low. Result channel: ways_mod
// moves when result_valid is high and result_stall is low, one per query.
//
// k = 0, k > n or n > MAX_N answer 0 with no sweep: the query goes from
// the idle state straight to the finish state. Otherwise the row store is
// swept once per row m = 1..n, updating columns min(m,k) down to 1, one
// update issued per cycle into a pipelined modular multiply-add unit, which
// drains before the next row.
// One query is in flight at a time: query_stall stays high until its result
// is loaded into the output register.
//
// Reset clears the sequencer and the output valid; the row store is not
// cleared (each query writes a column before it ever reads it). A stalled
// result holds ways_mod; the next query may still be taken, and its result
// waits in the last state until the output register frees.
module stirling_first_kind_mod_unit import stir_pkg::*; #(
  parameter int MAX_N = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               query_valid,
  output logic               query_stall,
  input  logic [QUERY_W-1:0] stick_count,
  input  logic [QUERY_W-1:0] visible_count,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [DATA_W-1:0]  ways_mod
);

  localparam int DEPTH = MAX_N + 1;
  localparam int CW = $clog2(DEPTH);
  localparam int WW = (CW > QUERY_W) ? CW : QUERY_W;
  localparam logic [WW-1:0] MAX_N_W = WW'(MAX_N);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RUN    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_CAPT   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]        state;
  logic [CW-1:0]     n_r;
  logic [CW-1:0]     k_r;
  logic [CW-1:0]     m_r;      // current row
  logic [CW-1:0]     j_r;      // column being issued
  logic [DATA_W-1:0] res;

  logic              reject;
  logic [CW-1:0]     m_inc;
  logic [CW-1:0]     top_next;
  logic              out_free;
  stir_op_t          op;
  logic [CW-1:0]     ra_addr;
  logic [CW-1:0]     rb_addr;
  logic [DATA_W-1:0] ra_data;
  logic [DATA_W-1:0] rb_data;
  logic              wr_en;
  logic [CW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              busy;

  // Hold off queries during reset and while a query is in work
  assign query_stall = rst || (state != S_IDLE);

  assign reject = (visible_count == '0) || (visible_count > stick_count) ||
                  (WW'(stick_count) > MAX_N_W);

  assign m_inc = m_r + CW'(1);
  assign top_next = (m_inc < k_r) ? m_inc : k_r;
  assign out_free = !result_valid || !result_stall;

  // Column j was never touched in this query when j equals the row number,
  // and column 0 is 1 only before the first row.
  assign op.valid = (state == S_RUN);
  assign op.hi_zero = (j_r == m_r);
  assign op.lo_seed = (j_r == CW'(1));
  assign op.seed_one = (m_r == CW'(1));

  assign ra_addr = (state == S_READ) ? k_r : j_r;
  assign rb_addr = (j_r == '0) ? '0 : j_r - CW'(1);

  stir_row_mem #(
    .DEPTH (DEPTH),
    .AW    (CW)
  ) u_mem (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  stir_mod_mac #(
    .AW (CW),
    .MW (CW)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .op_addr (j_r),
    .mult    (m_r - CW'(1)),
    .rd_hi   (ra_data),
    .rd_lo   (rb_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // load a finished result, otherwise drop a result the receiver took
      if (state == S_FINISH && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (query_valid) begin
            if (reject) begin
              res   <= '0;
              state <= S_FINISH;
            end else begin
              n_r   <= CW'(stick_count);
              k_r   <= CW'(visible_count);
              m_r   <= CW'(1);
              j_r   <= CW'(1);
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          // issue one column per cycle, top column first
          j_r <= j_r - CW'(1);
          if (j_r == CW'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // next row reads what this row writes: wait for the last write
          if (!busy) begin
            if (m_r == n_r) begin
              state <= S_READ;
            end else begin
              m_r   <= m_inc;
              j_r   <= top_next;
              state <= S_RUN;
            end
          end
        end
        S_READ: begin
          state <= S_CAPT;
        end
        S_CAPT: begin
          res   <= ra_data;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            ways_mod <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/stir_checker.sv */
module stir_checker import stir_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               query_valid,
  input logic               query_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic [DATA_W-1:0]  ways_mod
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(ways_mod))
    else $error("stalled result changed or dropped");

  // results are fully reduced
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ways_mod < MOD_P)
    else $error("result not reduced below modulus");

  // one query at a time: an accepted query blocks the next
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    query_valid && !query_stall |=> query_stall)
    else $error("query taken while another is in work");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind stirling_first_kind_mod_unit stir_checker u_stir_checker (.*);

/* dv/stirling_first_kind_mod_unit_tb.sv */
`timescale 1ns / 100ps

module stirling_first_kind_mod_unit_tb import stir_pkg::*;;

  localparam int unsigned MAX_N = 1024;
  localparam longint unsigned WAYS_P = 64'd1000000007;
  // Longest legal quiet stretch is one n = k = MAX_N query plus the longest
  // stall; allow several times that.
  localparam int unsigned WATCHDOG_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_QUERIES = 100;
  localparam int unsigned TAIL_CYCLES = 50;

  logic                clk;
  logic                rst;
  logic                query_valid;
  logic                query_stall;
  logic [QUERY_W-1:0]  stick_count;
  logic [QUERY_W-1:0]  visible_count;
  logic                result_valid;
  logic                result_stall;
  logic [DATA_W-1:0]   ways_mod;

  // Keep its own rolling row and the answers still owed by the block.
  class stirling_tracker;
    bit [DATA_W-1:0]   row_copy [0:MAX_N];
    logic [DATA_W-1:0] pending_ways [$];
    int unsigned       mismatches;
    int unsigned       checked;

    function new();
      foreach (row_copy[i]) row_copy[i] = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    // c(n,k) mod p, swept row by row through the rolling row.
    function bit [DATA_W-1:0] stirling_mod(int unsigned n, int unsigned k);
      longint unsigned acc;
      int unsigned top;
      if (k == 0 || k > n || n > MAX_N) return '0;
      row_copy[0] = 1;
      for (int unsigned j = 1; j <= k; j++) row_copy[j] = '0;
      for (int unsigned m = 1; m <= n; m++) begin
        top = (m < k) ? m : k;
        for (int j = top; j >= 1; j--) begin
          acc = longint'(row_copy[j-1]) + longint'(m - 1) * longint'(row_copy[j]);
          row_copy[j] = DATA_W'(acc % WAYS_P);
        end
        row_copy[0] = '0;
      end
      return row_copy[k];
    endfunction

    function void log_query(int unsigned n, int unsigned k);
      pending_ways.push_back(stirling_mod(n, k));
    endfunction

    function void check_ways(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      if (pending_ways.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: ways_mod=%0d with no query pending", $realtime, got);
        return;
      end
      want = pending_ways.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] ways_mod mismatch: expected %0d, got %0d", $realtime, want, got);
      end
    endfunction

    function int unsigned pending_count();
      return pending_ways.size();
    endfunction
  endclass

  stirling_tracker tracker;
  bit              calm_phase;
  int unsigned     queries_sent;
  int unsigned     zero_by_rule;
  int unsigned     widest_row;

  stirling_first_kind_mod_unit #(.MAX_N(MAX_N)) dut (
    .clk           (clk),
    .rst           (rst),
    .query_valid   (query_valid),
    .query_stall   (query_stall),
    .stick_count   (stick_count),
    .visible_count (visible_count),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .ways_mod      (ways_mod)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly back-to-back or short gaps, now and then a long one; none while calm.
  function automatic int unsigned rand_gap();
    int unsigned r;
    if (calm_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one query from a falling edge, hold it until the transaction
  // completes, then idle for a random gap. Returns at a falling edge.
  task automatic send_query(input bit [QUERY_W-1:0] n, input bit [QUERY_W-1:0] k);
    int unsigned gap;
    stick_count   <= n;
    visible_count <= k;
    query_valid   <= 1'b1;
    do @(posedge clk); while (query_stall);
    tracker.log_query(n, k);
    queries_sent++;
    if (k == 0 || k > n || n > MAX_N) zero_by_rule++;
    else if (n > widest_row) widest_row = n;
    @(negedge clk);
    gap = rand_gap();
    if (gap > 0) begin
      query_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off new queries until the block has answered everything.
  task automatic drain_results();
    query_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending_count() != 0);
  endtask

  // Random query: mostly real sweeps on small rows, a few longer thin rows,
  // and some noise that lands on the rejection or k > n paths.
  task automatic send_random_query();
    int unsigned r;
    int unsigned n;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      n = $urandom_range(0, 40);
      k = $urandom_range(0, n + 2);
    end else if (r < 80) begin
      n = $urandom_range(41, 300);
      k = $urandom_range(1, 4);
    end else if (r < 90) begin
      n = $urandom_range(MAX_N + 1, 2047);
      k = $urandom_range(0, 2047);
    end else begin
      n = $urandom_range(0, 2046);
      k = $urandom_range(n + 1, 2047);
    end
    send_query(n, k);
  endtask

  // Result side: toggle stall in runs so gaps land on every cycle of a result.
  initial begin
    int unsigned gap;
    result_stall = 1'b0;
    forever begin
      gap = rand_gap();
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // Check every completed result transaction at the rising edge.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) tracker.check_ways(ways_mod);
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((query_valid && !query_stall) || (result_valid && !result_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles, %0d results outstanding",
                 idle_cycles, tracker.pending_count());
        $display("FAIL stirling_first_kind_mod_unit");
        $finish;
      end
    end
  end

  initial begin
    tracker       = new();
    rst           = 1'b1;
    query_valid   = 1'b0;
    stick_count   = '0;
    visible_count = '0;
    calm_phase    = 1'b0;
    queries_sent  = 0;
    zero_by_rule  = 0;
    widest_row    = 0;

    // Hold reset, then release it on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero visible (n = 0 too), too many visible, small n,
    // rejection above MAX_N, all-ones fields, and the largest legal sweep.
    send_query(0, 0);
    send_query(0, 1);
    send_query(1, 0);
    send_query(1, 1);
    send_query(2, 1);
    send_query(2, 2);
    send_query(3, 1);
    send_query(3, 2);
    send_query(3, 3);
    send_query(5, 6);
    send_query(10, 3);
    send_query(12, 12);
    send_query(20, 10);
    send_query(4, 2047);
    send_query(1024, 0);
    send_query(1024, 1025);
    send_query(1025, 1);
    send_query(2047, 2047);
    send_query(2047, 0);
    send_query(1024, 1);
    send_query(1024, 2);
    // A rejected query must not disturb the next sweep.
    send_query(1100, 5);
    send_query(7, 4);
    send_query(1024, 1024);
    drain_results();

    for (int unsigned i = 0; i < RANDOM_QUERIES; i++) begin
      calm_phase = (i >= 20 && i < 40);
      if (i == 60) drain_results();
      send_random_query();
    end
    calm_phase = 1'b0;
    query_valid <= 1'b0;

    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d queries: %0d answered zero by rule or rejection, sweeps up to n = %0d.",
             queries_sent, zero_by_rule, widest_row);
    $display("Checked %0d results, %0d mismatches, %0d still pending.",
             tracker.checked, tracker.mismatches, tracker.pending_count());
    if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
      $display("PASS stirling_first_kind_mod_unit");
    end else begin
      $display("FAIL stirling_first_kind_mod_unit");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/stir_pkg.sv
hdl/stir_row_mem.sv
hdl/stir_mod_mac.sv
hdl/stirling_first_kind_mod_unit.sv
hdl/stir_checker.sv
dv/stirling_first_kind_mod_unit_tb.sv
